/* rtl/openpgp_packet_deframer_defines.svh */
// ---------------------------------------------------------------------------
// OpenPGP packet deframer assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef OPENPGP_PACKET_DEFRAMER_DEFINES_SVH
`define OPENPGP_PACKET_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define OPGPDF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define OPGPDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define OPGPDF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define OPGPDF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/opgpdf_pkg.sv */
// ---------------------------------------------------------------------------
// OpenPGP packet deframer package
// Phase, length format and error codes, and the header length table.
// ---------------------------------------------------------------------------
package opgpdf_pkg;

   typedef logic [1:0] phase_type;
   typedef logic [2:0] format_type;
   typedef logic [2:0] error_type;

   localparam phase_type PH_TAG  = 2'd0;
   localparam phase_type PH_LEN  = 2'd1;
   localparam phase_type PH_BODY = 2'd2;
   localparam phase_type PH_ERR  = 2'd3;

   localparam format_type FMT_NONE      = 3'd0;
   localparam format_type FMT_NEW_FIRST = 3'd1;
   localparam format_type FMT_ONE       = 3'd2;
   localparam format_type FMT_OLD_TWO   = 3'd3;
   localparam format_type FMT_NEW_TWO   = 3'd4;
   localparam format_type FMT_OLD_FOUR  = 3'd5;
   localparam format_type FMT_NEW_FIVE  = 3'd6;

   localparam error_type ERR_OK      = 3'd0;
   localparam error_type ERR_BAD_HDR = 3'd1;
   localparam error_type ERR_SHORT   = 3'd2;
   localparam error_type ERR_TOO_BIG = 3'd3;
   localparam error_type ERR_EXCESS  = 3'd4;

   localparam int RSP_TDATA_W = 56;
   localparam int RSP_TUSER_W = 3;

   function automatic logic [2:0] hdr_len(input format_type fmt);
      logic [2:0] len;
      unique case (fmt)
         FMT_ONE:      len = 3'd2;
         FMT_OLD_TWO:  len = 3'd3;
         FMT_NEW_TWO:  len = 3'd3;
         FMT_OLD_FOUR: len = 3'd5;
         FMT_NEW_FIVE: len = 3'd6;
         default:      len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

/* rtl/openpgp_packet_deframer.sv */
// ---------------------------------------------------------------------------
// OpenPGP packet deframer: splits a byte stream into packets.
// An accepted byte updates the header and body state and has its result in the
// output register in the next cycle. One byte per cycle unless the output stalls.
// Synchronous reset clears the state and the interest mask and empties the output.
// ---------------------------------------------------------------------------
`include "openpgp_packet_deframer_defines.svh"

module openpgp_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // stream_byte[7:0]
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // byte_out[7:0], packet_tag[13:8], header_done[14], packet_end[15],
   // header_length[18:16], body_length[49:19], error_code[52:50], zero[55:53]
   output logic [opgpdf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // header_byte[0], body_byte[1], of_interest[2]
   output logic [opgpdf_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic        rsp_tlast
);

   logic [63:0]            mask_ff;
   opgpdf_pkg::phase_type  phase_ff, phase_in;
   logic [5:0]             tag_ff, tag_in;
   opgpdf_pkg::format_type fmt_ff, fmt_in;
   logic [2:0]             hcnt_ff, hcnt_in;
   logic [31:0]            acc_ff, acc_in;
   logic [31:0]            rem_ff, rem_in;
   opgpdf_pkg::error_type  err_ff, err_in;
   logic [1:0]             bip_ff, bip_in;

   logic                   rsp_valid_ff;
   logic [opgpdf_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [opgpdf_pkg::RSP_TUSER_W-1:0] rsp_tuser_ff, rsp_tuser_in;
   logic                   rsp_tlast_ff;

   logic                   req_accept;
   logic [1:0]             pos;
   logic                   body_big;
   logic [5:0]             o_tag;
   logic                   o_hb, o_bb, o_oi, o_hd, o_pe;
   logic [2:0]             o_hl;
   logic [30:0]            o_bl;
   opgpdf_pkg::error_type  o_err;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      phase_in = phase_ff;
      tag_in   = tag_ff;
      fmt_in   = fmt_ff;
      hcnt_in  = hcnt_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      err_in   = err_ff;
      pos      = (bip_ff == 2'd3) ? 2'd3 : bip_ff + 2'd1;
      bip_in   = pos;
      body_big = acc_ff[31];
      o_tag    = 6'd0;
      o_hb     = 1'b0;
      o_bb     = 1'b0;
      o_oi     = 1'b0;
      o_hd     = 1'b0;
      o_pe     = 1'b0;
      o_hl     = 3'd0;
      o_bl     = 31'd0;
      unique case (phase_ff)
         opgpdf_pkg::PH_TAG: begin
            o_hb    = 1'b1;
            acc_in  = 32'd0;
            hcnt_in = 3'd1;
            if (!req_tdata[7]) begin
               err_in   = opgpdf_pkg::ERR_BAD_HDR;
               phase_in = opgpdf_pkg::PH_ERR;
            end else if (req_tdata[6]) begin
               tag_in   = req_tdata[5:0];
               o_tag    = req_tdata[5:0];
               fmt_in   = opgpdf_pkg::FMT_NEW_FIRST;
               phase_in = opgpdf_pkg::PH_LEN;
            end else begin
               tag_in = {2'b00, req_tdata[5:2]};
               o_tag  = {2'b00, req_tdata[5:2]};
               unique case (req_tdata[1:0])
                  2'd0: begin
                     fmt_in   = opgpdf_pkg::FMT_ONE;
                     phase_in = opgpdf_pkg::PH_LEN;
                  end
                  2'd1: begin
                     fmt_in   = opgpdf_pkg::FMT_OLD_TWO;
                     phase_in = opgpdf_pkg::PH_LEN;
                  end
                  2'd2: begin
                     fmt_in   = opgpdf_pkg::FMT_OLD_FOUR;
                     phase_in = opgpdf_pkg::PH_LEN;
                  end
                  default: begin
                     err_in   = opgpdf_pkg::ERR_BAD_HDR;
                     phase_in = opgpdf_pkg::PH_ERR;
                  end
               endcase
            end
         end
         opgpdf_pkg::PH_LEN: begin
            o_hb    = 1'b1;
            o_tag   = tag_ff;
            hcnt_in = hcnt_ff + 3'd1;
            if (fmt_ff == opgpdf_pkg::FMT_NEW_FIRST) begin
               if (req_tdata <= 8'hbf) begin
                  acc_in = {24'd0, req_tdata};
                  fmt_in = opgpdf_pkg::FMT_ONE;
               end else if (req_tdata <= 8'hdf) begin
                  acc_in = {19'd0, req_tdata[4:0], 8'd192};
                  fmt_in = opgpdf_pkg::FMT_NEW_TWO;
               end else if (req_tdata == 8'hff) begin
                  acc_in = 32'd0;
                  fmt_in = opgpdf_pkg::FMT_NEW_FIVE;
               end else begin
                  err_in   = opgpdf_pkg::ERR_BAD_HDR;
                  phase_in = opgpdf_pkg::PH_ERR;
               end
            end else if (fmt_ff == opgpdf_pkg::FMT_NEW_TWO) begin
               acc_in = acc_ff + {24'd0, req_tdata};
            end else begin
               acc_in = {acc_ff[23:0], req_tdata};
            end
            if (phase_in == opgpdf_pkg::PH_LEN) begin
               o_hl = opgpdf_pkg::hdr_len(fmt_in);
               if (o_hl != 3'd0 && hcnt_in == o_hl) begin
                  o_hd   = 1'b1;
                  o_bl   = acc_in[31] ? 31'h7fffffff : acc_in[30:0];
                  rem_in = acc_in;
                  if (acc_in == 32'd0) begin
                     o_pe     = 1'b1;
                     phase_in = opgpdf_pkg::PH_TAG;
                     bip_in   = 2'd0;
                  end else begin
                     phase_in = opgpdf_pkg::PH_BODY;
                  end
               end
            end else begin
               o_tag = 6'd0;
            end
         end
         opgpdf_pkg::PH_BODY: begin
            o_bb   = 1'b1;
            o_tag  = tag_ff;
            o_hl   = opgpdf_pkg::hdr_len(fmt_ff);
            o_bl   = body_big ? 31'h7fffffff : acc_ff[30:0];
            o_oi   = !body_big && mask_ff[tag_ff];
            rem_in = rem_ff - 32'd1;
            if (rem_in == 32'd0) begin
               o_pe = 1'b1;
               if (body_big) begin
                  err_in   = opgpdf_pkg::ERR_TOO_BIG;
                  phase_in = opgpdf_pkg::PH_ERR;
               end else begin
                  phase_in = opgpdf_pkg::PH_TAG;
                  bip_in   = 2'd0;
               end
            end
         end
         default: begin
         end
      endcase

      o_err = err_in;
      if (req_tlast) begin
         if (pos <= 2'd2) begin
            o_err = opgpdf_pkg::ERR_EXCESS;
         end else if (err_in == opgpdf_pkg::ERR_OK &&
                      (phase_in == opgpdf_pkg::PH_LEN || phase_in == opgpdf_pkg::PH_BODY)) begin
            o_err = opgpdf_pkg::ERR_SHORT;
         end
         phase_in = opgpdf_pkg::PH_TAG;
         tag_in   = 6'd0;
         fmt_in   = opgpdf_pkg::FMT_NONE;
         hcnt_in  = 3'd0;
         acc_in   = 32'd0;
         rem_in   = 32'd0;
         err_in   = opgpdf_pkg::ERR_OK;
         bip_in   = 2'd0;
      end

      rsp_tdata_in = {3'd0, o_err, o_bl, o_hl, o_pe, o_hd, o_tag, req_tdata};
      rsp_tuser_in = {o_oi, o_bb, o_hb};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 64'd0;
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= opgpdf_pkg::PH_TAG;
         tag_ff   <= 6'd0;
         fmt_ff   <= opgpdf_pkg::FMT_NONE;
         hcnt_ff  <= 3'd0;
         acc_ff   <= 32'd0;
         rem_ff   <= 32'd0;
         err_ff   <= opgpdf_pkg::ERR_OK;
         bip_ff   <= 2'd0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         fmt_ff   <= fmt_in;
         hcnt_ff  <= hcnt_in;
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
         err_ff   <= err_in;
         bip_ff   <= bip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
         rsp_tlast_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `OPGPDF_ASSERT_NEXT(a_clear_after_last, clock, reset, req_accept && req_tlast,
      phase_ff == opgpdf_pkg::PH_TAG && err_ff == opgpdf_pkg::ERR_OK && bip_ff == 2'd0)
   `OPGPDF_ASSERT_IMPLIES(a_body_count_live, clock, reset,
      phase_ff == opgpdf_pkg::PH_BODY, rem_ff != 32'd0)
   `OPGPDF_ASSERT_IMPLIES(a_interest_on_body, clock, reset,
      rsp_valid_ff && rsp_tuser_ff[2], rsp_tuser_ff[1] && !rsp_tuser_ff[0])
   `OPGPDF_ASSERT_IMPLIES(a_error_code_range, clock, reset,
      rsp_valid_ff, rsp_tdata_ff[52:50] <= opgpdf_pkg::ERR_EXCESS)

endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// OpenPGP packet deframer testbench
// Drives byte buffers of well-formed, truncated, malformed and oversized
// packets through the stream port and checks every result transaction
// against a cycle-free prediction of the deframer, over several masks.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 145;
   localparam int MAX_PRINTED    = 200;

   typedef struct packed {
      logic [7:0]            octet;
      logic [5:0]            tag;
      logic                  hdr_flag;
      logic                  body_flag;
      logic                  interest;
      logic                  hdr_done;
      logic                  pkt_end;
      logic [2:0]            hdr_len;
      logic [30:0]           body_len;
      opgpdf_pkg::error_type err;
      logic                  done;
   } deframe_result_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_item_type;

   typedef enum int {
      ENC_OLD_ONE, ENC_OLD_TWO, ENC_OLD_FOUR, ENC_NEW_ONE, ENC_NEW_TWO, ENC_NEW_FIVE
   } length_enc_type;

   typedef enum int { BAD_TOP_BIT, BAD_OLD_TYPE, BAD_NEW_FIRST } bad_header_type;

   typedef enum int {
      READY_ALWAYS, READY_HALF, READY_QUARTER, READY_EVERY_THIRD
   } stall_mode_type;

   class deframer_scoreboard;
      logic [63:0]            interest_mask = '0;
      opgpdf_pkg::phase_type  phase = opgpdf_pkg::PH_TAG;
      logic [5:0]             cur_tag = '0;
      opgpdf_pkg::format_type fmt = opgpdf_pkg::FMT_NONE;
      logic [2:0]             hdr_cnt = '0;
      logic [31:0]            len_acc = '0;
      logic [31:0]            body_left = '0;
      opgpdf_pkg::error_type  sticky = opgpdf_pkg::ERR_OK;
      logic [1:0]             pos_cnt = '0;
      deframe_result_type     expected_q[$];
      int                     errors = 0;
      int                     checked = 0;

      function void clear_stream();
         phase = opgpdf_pkg::PH_TAG;
         cur_tag = '0;
         fmt = opgpdf_pkg::FMT_NONE;
         hdr_cnt = '0;
         len_acc = '0;
         body_left = '0;
         sticky = opgpdf_pkg::ERR_OK;
         pos_cnt = '0;
      endfunction

      function logic [2:0] header_size(opgpdf_pkg::format_type f);
         case (f)
            opgpdf_pkg::FMT_ONE:      return 3'd2;
            opgpdf_pkg::FMT_OLD_TWO,
            opgpdf_pkg::FMT_NEW_TWO:  return 3'd3;
            opgpdf_pkg::FMT_OLD_FOUR: return 3'd5;
            opgpdf_pkg::FMT_NEW_FIVE: return 3'd6;
            default:                  return 3'd0;
         endcase
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         deframe_result_type r;
         logic [1:0]         pos;
         logic               big;
         r = '0;
         pos = (pos_cnt < 2'd3) ? pos_cnt + 2'd1 : 2'd3;
         pos_cnt = pos;
         r.octet = b;
         r.done = last;
         case (phase)
            opgpdf_pkg::PH_TAG: begin
               r.hdr_flag = 1'b1;
               len_acc = '0;
               hdr_cnt = 3'd1;
               if (!b[7]) begin
                  sticky = opgpdf_pkg::ERR_BAD_HDR;
                  phase = opgpdf_pkg::PH_ERR;
               end else if (b[6]) begin
                  cur_tag = b[5:0];
                  fmt = opgpdf_pkg::FMT_NEW_FIRST;
                  phase = opgpdf_pkg::PH_LEN;
                  r.tag = cur_tag;
               end else begin
                  cur_tag = {2'b00, b[5:2]};
                  r.tag = cur_tag;
                  phase = opgpdf_pkg::PH_LEN;
                  case (b[1:0])
                     2'd0:    fmt = opgpdf_pkg::FMT_ONE;
                     2'd1:    fmt = opgpdf_pkg::FMT_OLD_TWO;
                     2'd2:    fmt = opgpdf_pkg::FMT_OLD_FOUR;
                     default: begin
                        sticky = opgpdf_pkg::ERR_BAD_HDR;
                        phase = opgpdf_pkg::PH_ERR;
                     end
                  endcase
               end
            end
            opgpdf_pkg::PH_LEN: begin
               r.hdr_flag = 1'b1;
               r.tag = cur_tag;
               hdr_cnt = hdr_cnt + 3'd1;
               if (fmt == opgpdf_pkg::FMT_NEW_FIRST) begin
                  if (b <= 8'hbf) begin
                     len_acc = {24'h0, b};
                     fmt = opgpdf_pkg::FMT_ONE;
                  end else if (b <= 8'hdf) begin
                     len_acc = ((32'(b) - 32'd192) << 8) + 32'd192;
                     fmt = opgpdf_pkg::FMT_NEW_TWO;
                  end else if (b == 8'hff) begin
                     len_acc = '0;
                     fmt = opgpdf_pkg::FMT_NEW_FIVE;
                  end else begin
                     sticky = opgpdf_pkg::ERR_BAD_HDR;
                     phase = opgpdf_pkg::PH_ERR;
                  end
               end else if (fmt == opgpdf_pkg::FMT_NEW_TWO) begin
                  len_acc = len_acc + 32'(b);
               end else begin
                  len_acc = {len_acc[23:0], b};
               end
               if (phase == opgpdf_pkg::PH_LEN) begin
                  r.hdr_len = header_size(fmt);
                  if (r.hdr_len != 3'd0 && hdr_cnt == r.hdr_len) begin
                     r.hdr_done = 1'b1;
                     r.body_len = len_acc[31] ? 31'h7fff_ffff : len_acc[30:0];
                     body_left = len_acc;
                     if (body_left == 32'd0) begin
                        r.pkt_end = 1'b1;
                        phase = opgpdf_pkg::PH_TAG;
                        pos_cnt = '0;
                     end else begin
                        phase = opgpdf_pkg::PH_BODY;
                     end
                  end
               end else begin
                  r.tag = '0;
               end
            end
            opgpdf_pkg::PH_BODY: begin
               big = len_acc[31];
               r.body_flag = 1'b1;
               r.tag = cur_tag;
               r.hdr_len = header_size(fmt);
               r.body_len = big ? 31'h7fff_ffff : len_acc[30:0];
               r.interest = !big && interest_mask[cur_tag];
               body_left = body_left - 32'd1;
               if (body_left == 32'd0) begin
                  r.pkt_end = 1'b1;
                  if (big) begin
                     sticky = opgpdf_pkg::ERR_TOO_BIG;
                     phase = opgpdf_pkg::PH_ERR;
                  end else begin
                     phase = opgpdf_pkg::PH_TAG;
                     pos_cnt = '0;
                  end
               end
            end
            default: ;
         endcase
         r.err = sticky;
         if (last) begin
            if (pos <= 2'd2)
               r.err = opgpdf_pkg::ERR_EXCESS;
            else if (sticky == opgpdf_pkg::ERR_OK &&
                     (phase == opgpdf_pkg::PH_LEN || phase == opgpdf_pkg::PH_BODY))
               r.err = opgpdf_pkg::ERR_SHORT;
            clear_stream();
         end
         expected_q.push_back(r);
      endfunction

      task report(string msg);
         if (errors < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_field(string name, longint unsigned got, longint unsigned want);
         if (got != want)
            report($sformatf("result %0d %s = 0x%0h, expected 0x%0h",
                             checked, name, got, want));
      endtask

      task check_result(logic [opgpdf_pkg::RSP_TDATA_W-1:0] tdata,
                        logic [opgpdf_pkg::RSP_TUSER_W-1:0] tuser, logic tlast);
         deframe_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result transaction, tdata 0x%0h", tdata));
         end else begin
            want = expected_q.pop_front();
            check_field("byte_out", 64'(tdata[7:0]), 64'(want.octet));
            check_field("packet_tag", 64'(tdata[13:8]), 64'(want.tag));
            check_field("header_done", 64'(tdata[14]), 64'(want.hdr_done));
            check_field("packet_end", 64'(tdata[15]), 64'(want.pkt_end));
            check_field("header_length", 64'(tdata[18:16]), 64'(want.hdr_len));
            check_field("body_length", 64'(tdata[49:19]), 64'(want.body_len));
            check_field("error_code", 64'(tdata[52:50]), 64'(want.err));
            check_field("tdata padding", 64'(tdata[55:53]), 64'd0);
            check_field("header_byte", 64'(tuser[0]), 64'(want.hdr_flag));
            check_field("body_byte", 64'(tuser[1]), 64'(want.body_flag));
            check_field("of_interest", 64'(tuser[2]), 64'(want.interest));
            check_field("stream_done", 64'(tlast), 64'(want.done));
            checked++;
         end
      endtask
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_wr_en = 1'b0;
   logic [63:0]                        csr_wr_data = '0;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [7:0]                         req_tdata = '0;
   logic                               req_tlast = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b1;
   logic [opgpdf_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [opgpdf_pkg::RSP_TUSER_W-1:0] rsp_tuser;
   logic                               rsp_tlast;

   deframer_scoreboard sb = new();
   stream_item_type    stim_q[$];
   logic [7:0]         pkt_q[$];
   int                 quiet_cycles = 0;
   stall_mode_type     stall_mode = READY_ALWAYS;
   int                 stall_count = 0;

   openpgp_packet_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (stall_count == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_count <= $urandom_range(16, 80);
      end else begin
         stall_count <= stall_count - 1;
      end
      case (stall_mode)
         READY_ALWAYS:  rsp_tready <= 1'b1;
         READY_HALF:    rsp_tready <= 1'($urandom_range(0, 1));
         READY_QUARTER: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:       rsp_tready <= (stall_count % 3 == 0);
      endcase
   end

   // Inputs are noted before outputs are checked, so a result in the same
   // cycle as its transaction would still find its expectation.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready)
            sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task write_mask(input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.interest_mask = value;
      csr_wr_en <= 1'b0;
   endtask

   task send_item(input stream_item_type item);
      req_tvalid <= 1'b1;
      req_tdata <= item.data;
      req_tlast <= item.last;
      do @(posedge clock); while (!req_tready);
   endtask

   task drive_stimulus();
      int burst;
      int gap;
      while (stim_q.size() != 0) begin
         burst = $urandom_range(1, 48);
         while (burst > 0 && stim_q.size() != 0) begin
            send_item(stim_q.pop_front());
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task wait_results();
      do @(posedge clock); while (sb.expected_q.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task commit(input int count);
      int i;
      for (i = 0; i < count; i++)
         stim_q.push_back('{data: pkt_q[i], last: 1'b0});
      pkt_q.delete();
   endtask

   task end_buffer();
      stim_q[stim_q.size() - 1].last = 1'b1;
   endtask

   task build_packet(input logic [5:0] tag, input length_enc_type enc,
                     input logic [31:0] len, input int body_n);
      logic [31:0] v;
      v = len - 32'd192;
      case (enc)
         ENC_OLD_ONE: begin
            pkt_q.push_back({2'b10, tag[3:0], 2'b00});
            pkt_q.push_back(len[7:0]);
         end
         ENC_OLD_TWO: begin
            pkt_q.push_back({2'b10, tag[3:0], 2'b01});
            pkt_q.push_back(len[15:8]);
            pkt_q.push_back(len[7:0]);
         end
         ENC_OLD_FOUR: begin
            pkt_q.push_back({2'b10, tag[3:0], 2'b10});
            pkt_q.push_back(len[31:24]);
            pkt_q.push_back(len[23:16]);
            pkt_q.push_back(len[15:8]);
            pkt_q.push_back(len[7:0]);
         end
         ENC_NEW_ONE: begin
            pkt_q.push_back({2'b11, tag});
            pkt_q.push_back(len[7:0]);
         end
         ENC_NEW_TWO: begin
            pkt_q.push_back({2'b11, tag});
            pkt_q.push_back({3'b110, v[12:8]});
            pkt_q.push_back(v[7:0]);
         end
         default: begin
            pkt_q.push_back({2'b11, tag});
            pkt_q.push_back(8'hff);
            pkt_q.push_back(len[31:24]);
            pkt_q.push_back(len[23:16]);
            pkt_q.push_back(len[15:8]);
            pkt_q.push_back(len[7:0]);
         end
      endcase
      repeat (body_n) pkt_q.push_back(8'($urandom_range(0, 255)));
   endtask

   task add_good_packet();
      length_enc_type enc;
      logic [31:0]    len;
      enc = length_enc_type'($urandom_range(0, 5));
      if (enc == ENC_NEW_TWO && $urandom_range(0, 49) != 0)
         enc = ENC_NEW_FIVE;
      len = (enc == ENC_NEW_TWO) ? $urandom_range(192, 200) : $urandom_range(0, 6);
      build_packet(6'($urandom_range(0, 63)), enc, len, int'(len));
      commit(pkt_q.size());
   endtask

   task add_truncated_packet();
      length_enc_type enc;
      logic [31:0]    len;
      int             body_n;
      longint         full;
      longint         cut_max;
      enc = length_enc_type'($urandom_range(0, 5));
      case (enc)
         ENC_OLD_ONE: len = $urandom_range(0, 255);
         ENC_NEW_ONE: len = $urandom_range(0, 191);
         ENC_OLD_TWO: len = $urandom_range(0, 65535);
         ENC_NEW_TWO: len = $urandom_range(192, 8383);
         default:     len = $urandom;
      endcase
      body_n = $urandom_range(0, 4);
      if (len < body_n)
         body_n = int'(len);
      build_packet(6'($urandom_range(0, 63)), enc, len, body_n);
      full = longint'(pkt_q.size() - body_n) + longint'(len);
      cut_max = (pkt_q.size() < full) ? pkt_q.size() : full - 1;
      commit($urandom_range(1, int'(cut_max)));
   endtask

   task add_bad_header();
      bad_header_type kind;
      kind = bad_header_type'($urandom_range(0, 2));
      case (kind)
         BAD_TOP_BIT:  pkt_q.push_back(8'($urandom_range(0, 127)));
         BAD_OLD_TYPE: pkt_q.push_back({2'b10, 4'($urandom_range(0, 15)), 2'b11});
         default: begin
            pkt_q.push_back({2'b11, 6'($urandom_range(0, 63))});
            pkt_q.push_back(8'($urandom_range(8'he0, 8'hfe)));
         end
      endcase
      repeat ($urandom_range(0, 5)) pkt_q.push_back(8'($urandom_range(0, 255)));
      commit(pkt_q.size());
   endtask

   task gen_buffer();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         repeat ($urandom_range(1, 4)) add_good_packet();
      end else if (kind < 80) begin
         repeat ($urandom_range(0, 2)) add_good_packet();
         add_truncated_packet();
      end else if (kind < 88) begin
         repeat ($urandom_range(0, 2)) add_good_packet();
         add_bad_header();
      end else if (kind < 93) begin
         repeat ($urandom_range(0, 1)) add_good_packet();
         build_packet(6'($urandom_range(0, 63)),
                      $urandom_range(0, 1) ? ENC_OLD_FOUR : ENC_NEW_FIVE,
                      32'h8000_0000 | $urandom, $urandom_range(0, 5));
         commit(pkt_q.size());
      end else begin
         repeat ($urandom_range(1, 8)) pkt_q.push_back(8'($urandom_range(0, 255)));
         commit(pkt_q.size());
      end
      end_buffer();
   endtask

   task add_directed();
      // Clean buffer of an old one-byte and a new five-byte packet.
      build_packet(6'd15, ENC_OLD_ONE, 32'd2, 0);
      pkt_q.push_back(8'h00);
      pkt_q.push_back(8'hff);
      build_packet(6'd63, ENC_NEW_FIVE, 32'd1, 0);
      pkt_q.push_back(8'h5a);
      commit(pkt_q.size());
      end_buffer();
      // A lone byte without its top bit ends the buffer on the first byte.
      pkt_q.push_back(8'h00);
      commit(pkt_q.size());
      end_buffer();
      // Old length type 3, then new format with a partial length byte.
      pkt_q.push_back(8'h83);
      pkt_q.push_back(8'h12);
      pkt_q.push_back(8'h34);
      commit(pkt_q.size());
      end_buffer();
      pkt_q.push_back(8'hc1);
      pkt_q.push_back(8'he0);
      pkt_q.push_back(8'h00);
      commit(pkt_q.size());
      end_buffer();
      // Oversized length with the buffer ending inside the body.
      build_packet(6'd0, ENC_OLD_FOUR, 32'h8000_0000, 1);
      commit(pkt_q.size());
      end_buffer();
   endtask

   initial begin
      logic [63:0] masks [6];
      int          i;
      masks = '{64'h0, {$urandom, $urandom}, 64'h5555_5555_5555_5555,
                64'haaaa_aaaa_aaaa_aaaa, {$urandom, $urandom}, '1};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mask('1);
      add_directed();
      drive_stimulus();
      wait_results();
      for (i = 0; i < 6; i++) begin
         write_mask(masks[i]);
         while (stim_q.size() < PHASE_ITEMS) gen_buffer();
         drive_stimulus();
         wait_results();
      end
      if (sb.expected_q.size() != 0)
         sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* openpgp_packet_deframer.f */
+incdir+rtl
rtl/opgpdf_pkg.sv
rtl/openpgp_packet_deframer.sv
tb/tb.sv
